// ----- hw/rtl/csl_pkg.sv -----
package csl_pkg;

	// Default sizing of the list
	localparam int CAPACITY   = 32;
	localparam int DATA_WIDTH = 32;

	// Fixed field widths on the ports
	localparam int ENTRY_W = 32;
	localparam int COUNT_W = 6;
	localparam int MODE_W  = 3;
	localparam int STAT_W  = 2;

	// Command codes
	localparam logic [MODE_W-1:0] MODE_START   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_ADVANCE = 3'd1;
	localparam logic [MODE_W-1:0] MODE_INSERT  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_ATTACH  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_REMOVE  = 3'd4;
	localparam logic [MODE_W-1:0] MODE_READ    = 3'd5;

	// Status codes
	localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL   = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NOITEM = 2'd2;

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [ENTRY_W-1:0] entry_value;
	} req_t;

	typedef struct packed {
		logic [ENTRY_W-1:0] current_value;
		logic               has_current;
		logic [COUNT_W-1:0] item_count;
		logic [STAT_W-1:0]  status;
	} rsp_t;

endpackage

// ----- hw/rtl/csl_ram.sv -----
module csl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port, hold data between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hw/rtl/csl_ctrl.sv -----
module csl_ctrl #(
	parameter int CAPACITY   = csl_pkg::CAPACITY,
	parameter int DATA_WIDTH = csl_pkg::DATA_WIDTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  csl_pkg::req_t               req,
	output logic                        ram_we,
	output logic [$clog2(CAPACITY)-1:0] ram_waddr,
	output logic [DATA_WIDTH-1:0]       ram_wdata,
	output logic                        ram_re,
	output logic [$clog2(CAPACITY)-1:0] ram_raddr,
	input  logic [DATA_WIDTH-1:0]       ram_rdata,
	input  logic                        slot_free,
	output logic                        res_push,
	output csl_pkg::rsp_t               res
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_SHIFT = 6'b000010,
		S_FILL  = 6'b000100,
		S_LOOK  = 6'b001000,
		S_WAIT  = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t                     state_q;
	logic [CW-1:0]              count_q;
	logic [CW-1:0]              cursor_q;
	logic [CW-1:0]              rd_ptr_q;
	logic [CW-1:0]              rem_q;
	logic                       down_q;
	logic                       is_ins_q;
	logic [csl_pkg::STAT_W-1:0] status_q;
	logic [DATA_WIDTH-1:0]      val_q;
	logic [DATA_WIDTH-1:0]      cur_val_q;
	logic                       pend_s1;
	logic [AW-1:0]              waddr_s1;

	logic                  has_item;
	logic                  full;
	logic                  accept;
	logic [63:0]           entry_ext;
	logic [DATA_WIDTH-1:0] entry_masked;
	logic [CW-1:0]         ins_pos;
	logic [CW-1:0]         rd_next;
	logic [CW-1:0]         wr_next;
	logic [63:0]           cur_ext;
	logic [15:0]           count_ext;

	assign has_item     = cursor_q < count_q;
	assign full         = count_q == CW'(CAPACITY);
	assign req_ready    = state_q == S_IDLE;
	assign accept       = req_valid && req_ready;
	assign entry_ext    = 64'(req.entry_value);
	assign entry_masked = entry_ext[DATA_WIDTH-1:0];

	// Slot that the new item lands in
	always_comb begin
		if (req.mode == csl_pkg::MODE_INSERT) begin
			ins_pos = has_item ? cursor_q : '0;
		end else begin
			ins_pos = has_item ? cursor_q + CW'(1) : count_q;
		end
	end

	// Step the shift pointer; the write lands one slot away from the read
	assign rd_next = down_q ? rd_ptr_q - CW'(1) : rd_ptr_q + CW'(1);
	assign wr_next = down_q ? rd_ptr_q + CW'(1) : rd_ptr_q - CW'(1);

	// Drive the memory ports
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = rd_ptr_q[AW-1:0];
		ram_we    = 1'b0;
		ram_waddr = waddr_s1;
		ram_wdata = ram_rdata;
		if (state_q == S_SHIFT) begin
			ram_re = rem_q != '0;
			ram_we = pend_s1;
		end else if (state_q == S_FILL) begin
			ram_we    = 1'b1;
			ram_waddr = cursor_q[AW-1:0];
			ram_wdata = val_q;
		end else if (state_q == S_LOOK) begin
			ram_re    = has_item;
			ram_raddr = cursor_q[AW-1:0];
		end
	end

	// Track a read in flight during the shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= (state_q == S_SHIFT) && (rem_q != '0);
		end
	end

	always_ff @(posedge clk) begin
		waddr_s1 <= wr_next[AW-1:0];
	end

	// Command sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			cursor_q <= '0;
			rd_ptr_q <= '0;
			rem_q    <= '0;
			down_q   <= 1'b0;
			is_ins_q <= 1'b0;
			status_q <= csl_pkg::STAT_OK;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						status_q <= csl_pkg::STAT_OK;
						state_q  <= S_LOOK;
						case (req.mode)
							csl_pkg::MODE_START: begin
								cursor_q <= '0;
							end
							csl_pkg::MODE_ADVANCE: begin
								if (has_item) begin
									cursor_q <= cursor_q + CW'(1);
								end else begin
									status_q <= csl_pkg::STAT_NOITEM;
								end
							end
							csl_pkg::MODE_INSERT, csl_pkg::MODE_ATTACH: begin
								if (full) begin
									status_q <= csl_pkg::STAT_FULL;
								end else begin
									cursor_q <= ins_pos;
									rd_ptr_q <= count_q - CW'(1);
									rem_q    <= count_q - ins_pos;
									down_q   <= 1'b1;
									is_ins_q <= 1'b1;
									state_q  <= S_SHIFT;
								end
							end
							csl_pkg::MODE_REMOVE: begin
								if (has_item) begin
									rd_ptr_q <= cursor_q + CW'(1);
									rem_q    <= count_q - cursor_q - CW'(1);
									down_q   <= 1'b0;
									is_ins_q <= 1'b0;
									state_q  <= S_SHIFT;
								end else begin
									status_q <= csl_pkg::STAT_NOITEM;
								end
							end
							csl_pkg::MODE_READ: begin
								if (!has_item) begin
									status_q <= csl_pkg::STAT_NOITEM;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_SHIFT: begin
					if (rem_q != '0) begin
						rd_ptr_q <= rd_next;
						rem_q    <= rem_q - CW'(1);
					end else if (!pend_s1) begin
						if (is_ins_q) begin
							state_q <= S_FILL;
						end else begin
							count_q <= count_q - CW'(1);
							state_q <= S_LOOK;
						end
					end
				end
				S_FILL: begin
					count_q <= count_q + CW'(1);
					state_q <= S_DONE;
				end
				S_LOOK: begin
					state_q <= has_item ? S_WAIT : S_DONE;
				end
				S_WAIT: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Hold the new data word and the value reported as current
	always_ff @(posedge clk) begin
		if (accept) begin
			val_q <= entry_masked;
		end
		if (state_q == S_FILL) begin
			cur_val_q <= val_q;
		end else if (state_q == S_WAIT) begin
			cur_val_q <= ram_rdata;
		end else if (state_q == S_LOOK && !has_item) begin
			cur_val_q <= '0;
		end
	end

	// Build the result
	assign cur_ext  = 64'(cur_val_q);
	assign count_ext = 16'(count_q);
	assign res_push = (state_q == S_DONE) && slot_free;

	always_comb begin
		res.current_value = cur_ext[csl_pkg::ENTRY_W-1:0];
		res.has_current   = has_item;
		res.item_count    = count_ext[csl_pkg::COUNT_W-1:0];
		res.status        = status_q;
	end

endmodule

// ----- hw/rtl/cursor_sequence_list_unit.sv -----
// Ordered list of up to CAPACITY data words with a cursor, held in a 1R1W
// RAM. One request is worked on at a time; the next is taken while the last
// result still waits in the output register. Start, advance, read and the
// unused modes move no entries. Insert and attach move (count - slot)
// entries and remove moves (count - cursor - 1), one entry per cycle while
// the gap is opened or closed; rejected commands move none. A full
// output register holds the sequencer until the result is taken. No clearing
// pass runs after reset; entries are read only once written.
module cursor_sequence_list_unit #(
	parameter int CAPACITY   = csl_pkg::CAPACITY,
	parameter int DATA_WIDTH = csl_pkg::DATA_WIDTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  csl_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output csl_pkg::rsp_t rsp
);

	localparam int AW = $clog2(CAPACITY);

	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [DATA_WIDTH-1:0] ram_wdata;
	logic                  ram_re;
	logic [AW-1:0]         ram_raddr;
	logic [DATA_WIDTH-1:0] ram_rdata;
	logic                  slot_free;
	logic                  res_push;
	csl_pkg::rsp_t         res;
	logic                  rsp_valid_q;
	csl_pkg::rsp_t         rsp_q;

	csl_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	csl_ctrl #(
		.CAPACITY  (CAPACITY),
		.DATA_WIDTH(DATA_WIDTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.ram_we   (ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_re   (ram_re),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata),
		.slot_free(slot_free),
		.res_push (res_push),
		.res      (res)
	);

	// Output register: load when empty or being drained
	assign slot_free = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (slot_free) begin
			rsp_valid_q <= res_push;
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- hw/rtl/csl_chk.sv -----
module csl_chk #(
	parameter int CAPACITY = csl_pkg::CAPACITY
) (
	input logic          clk,
	input logic          arst_n,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input csl_pkg::rsp_t rsp
);

	// Stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	// No current item reports a zero value
	a_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.has_current |-> rsp.current_value == '0)
		else $error("value reported without a current item");

	// Only defined status codes appear
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.status == csl_pkg::STAT_OK || rsp.status == csl_pkg::STAT_FULL
			|| rsp.status == csl_pkg::STAT_NOITEM))
		else $error("undefined status code");

	// A full rejection comes only from a full list
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == csl_pkg::STAT_FULL
			|-> rsp.item_count == csl_pkg::COUNT_W'(CAPACITY))
		else $error("full status with list not full");

	// A no-item rejection leaves no current item
	a_noitem: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == csl_pkg::STAT_NOITEM |-> !rsp.has_current)
		else $error("no-item status with a current item");

endmodule

bind cursor_sequence_list_unit csl_chk #(
	.CAPACITY(CAPACITY)
) u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.rsp      (rsp)
);

// ----- tb/cursor_sequence_list_unit_tb.sv -----
module cursor_sequence_list_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIST_DEPTH     = csl_pkg::CAPACITY;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_CYCLES    = 400;
	localparam int SETTLE_CYCLES  = 60;

	// Mode codes the block treats as no-ops
	localparam logic [csl_pkg::MODE_W-1:0] MODE_SPARE_A = 3'd6;
	localparam logic [csl_pkg::MODE_W-1:0] MODE_SPARE_B = 3'd7;

	typedef enum int {GROW, MIXED, SHRINK} list_bias_t;

	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	logic          req_valid = 1'b0;
	logic          req_ready;
	csl_pkg::req_t req       = '0;
	logic          rsp_valid;
	logic          rsp_ready = 1'b0;
	csl_pkg::rsp_t rsp;

	// Stimulus and pacing
	csl_pkg::req_t pending_cmds[$];
	int            send_idle_pct  = 0;
	int            recv_stall_pct = 0;
	logic          hold_rsp       = 1'b0;

	// Mirror of the list contents
	logic [csl_pkg::ENTRY_W-1:0] list_words[LIST_DEPTH];
	int                          list_count  = 0;
	int                          list_cursor = 0;
	csl_pkg::rsp_t               expected_replies[$];

	// Bookkeeping
	int n_accepted   = 0;
	int n_checked    = 0;
	int n_errors     = 0;
	int n_full       = 0;
	int n_noitem     = 0;
	int peak_count   = 0;
	int quiet_cycles = 0;

	cursor_sequence_list_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Apply one command to the mirror and return the reply it should produce
	function automatic csl_pkg::rsp_t apply_command(csl_pkg::req_t cmd);
		csl_pkg::rsp_t               reply;
		logic [csl_pkg::STAT_W-1:0]  stat;
		logic [csl_pkg::ENTRY_W-1:0] word;
		logic [63:0]                 keep_mask;
		int                          i;
		keep_mask = (64'h1 << csl_pkg::DATA_WIDTH) - 64'h1;
		word = csl_pkg::ENTRY_W'(64'(cmd.entry_value) & keep_mask);
		stat = csl_pkg::STAT_OK;
		case (cmd.mode)
			csl_pkg::MODE_START: begin
				list_cursor = 0;
			end
			csl_pkg::MODE_ADVANCE: begin
				if (list_cursor < list_count)
					list_cursor++;
				else
					stat = csl_pkg::STAT_NOITEM;
			end
			csl_pkg::MODE_INSERT: begin
				if (list_count >= LIST_DEPTH) begin
					stat = csl_pkg::STAT_FULL;
				end else begin
					if (list_cursor >= list_count)
						list_cursor = 0;
					for (i = list_count; i > list_cursor; i--)
						list_words[i] = list_words[i-1];
					list_words[list_cursor] = word;
					list_count++;
				end
			end
			csl_pkg::MODE_ATTACH: begin
				if (list_count >= LIST_DEPTH) begin
					stat = csl_pkg::STAT_FULL;
				end else if (list_cursor >= list_count) begin
					list_cursor = list_count;
					list_words[list_cursor] = word;
					list_count++;
				end else begin
					for (i = list_count; i > list_cursor + 1; i--)
						list_words[i] = list_words[i-1];
					list_words[list_cursor+1] = word;
					list_cursor++;
					list_count++;
				end
			end
			csl_pkg::MODE_REMOVE: begin
				if (list_cursor >= list_count) begin
					stat = csl_pkg::STAT_NOITEM;
				end else begin
					for (i = list_cursor + 1; i < list_count; i++)
						list_words[i-1] = list_words[i];
					list_count--;
				end
			end
			csl_pkg::MODE_READ: begin
				if (list_cursor >= list_count)
					stat = csl_pkg::STAT_NOITEM;
			end
			default: ;
		endcase
		if (list_count > peak_count)
			peak_count = list_count;
		reply.has_current   = (list_cursor < list_count);
		reply.current_value = reply.has_current ? list_words[list_cursor] : '0;
		reply.item_count    = csl_pkg::COUNT_W'(list_count);
		reply.status        = stat;
		return reply;
	endfunction

	function automatic logic [csl_pkg::ENTRY_W-1:0] random_word();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			return '0;
		if (pick == 1)
			return '1;
		return csl_pkg::ENTRY_W'($urandom);
	endfunction

	// Draw one command, leaning toward growing or shrinking the list
	function automatic csl_pkg::req_t random_cmd(list_bias_t bias);
		csl_pkg::req_t cmd;
		int            roll;
		roll = $urandom_range(0, 99);
		cmd.entry_value = random_word();
		case (bias)
			GROW: begin
				if (roll < 40)      cmd.mode = csl_pkg::MODE_INSERT;
				else if (roll < 75) cmd.mode = csl_pkg::MODE_ATTACH;
				else if (roll < 82) cmd.mode = csl_pkg::MODE_ADVANCE;
				else if (roll < 88) cmd.mode = csl_pkg::MODE_START;
				else if (roll < 93) cmd.mode = csl_pkg::MODE_READ;
				else if (roll < 96) cmd.mode = csl_pkg::MODE_REMOVE;
				else                cmd.mode = roll[0] ? MODE_SPARE_A : MODE_SPARE_B;
			end
			SHRINK: begin
				if (roll < 50)      cmd.mode = csl_pkg::MODE_REMOVE;
				else if (roll < 62) cmd.mode = csl_pkg::MODE_START;
				else if (roll < 72) cmd.mode = csl_pkg::MODE_ADVANCE;
				else if (roll < 80) cmd.mode = csl_pkg::MODE_READ;
				else if (roll < 88) cmd.mode = csl_pkg::MODE_INSERT;
				else if (roll < 95) cmd.mode = csl_pkg::MODE_ATTACH;
				else                cmd.mode = roll[0] ? MODE_SPARE_A : MODE_SPARE_B;
			end
			default: begin
				if (roll < 18)      cmd.mode = csl_pkg::MODE_INSERT;
				else if (roll < 36) cmd.mode = csl_pkg::MODE_ATTACH;
				else if (roll < 54) cmd.mode = csl_pkg::MODE_REMOVE;
				else if (roll < 68) cmd.mode = csl_pkg::MODE_ADVANCE;
				else if (roll < 78) cmd.mode = csl_pkg::MODE_START;
				else if (roll < 92) cmd.mode = csl_pkg::MODE_READ;
				else                cmd.mode = roll[0] ? MODE_SPARE_A : MODE_SPARE_B;
			end
		endcase
		return cmd;
	endfunction

	task automatic push_cmd(logic [csl_pkg::MODE_W-1:0] mode,
			logic [csl_pkg::ENTRY_W-1:0] value);
		csl_pkg::req_t cmd;
		cmd.mode        = mode;
		cmd.entry_value = value;
		pending_cmds.push_back(cmd);
	endtask

	// Queue random bursts, rotating the bias so the list swings empty to full
	task automatic queue_random(int total);
		int         left;
		int         len;
		list_bias_t bias;
		left = total;
		bias = GROW;
		while (left > 0) begin
			len = $urandom_range(30, 70);
			if (len > left)
				len = left;
			repeat (len) pending_cmds.push_back(random_cmd(bias));
			left -= len;
			bias = (bias == GROW) ? MIXED : (bias == MIXED) ? SHRINK : GROW;
		end
	endtask

	task automatic wait_drained();
		while (pending_cmds.size() != 0 || req_valid || expected_replies.size() != 0)
			@(negedge clk);
	endtask

	task automatic check_field(string name, logic [csl_pkg::ENTRY_W-1:0] want,
			logic [csl_pkg::ENTRY_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			n_errors++;
		end
	endtask

	// Present requests from the pending queue, idling at random between them
	always @(posedge clk) begin : drive_req
		logic next_valid;
		if (arst_n) begin
			next_valid = req_valid;
			if (req_valid && req_ready) begin
				expected_replies.push_back(apply_command(req));
				n_accepted++;
				next_valid = 1'b0;
			end
			if (!next_valid && pending_cmds.size() != 0 &&
					$urandom_range(0, 99) >= send_idle_pct) begin
				req <= pending_cmds.pop_front();
				next_valid = 1'b1;
			end
			req_valid <= next_valid;
		end
	end

	// Check each reply against the oldest expectation and pace rsp_ready
	always @(posedge clk) begin : check_rsp
		csl_pkg::rsp_t want;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (expected_replies.size() == 0) begin
					$display("%0t: reply with nothing expected, actual %p", $time, rsp);
					n_errors++;
				end else begin
					want = expected_replies.pop_front();
					check_field("current_value", want.current_value, rsp.current_value);
					check_field("has_current", csl_pkg::ENTRY_W'(want.has_current),
						csl_pkg::ENTRY_W'(rsp.has_current));
					check_field("item_count", csl_pkg::ENTRY_W'(want.item_count),
						csl_pkg::ENTRY_W'(rsp.item_count));
					check_field("status", csl_pkg::ENTRY_W'(want.status),
						csl_pkg::ENTRY_W'(rsp.status));
					if (want.status == csl_pkg::STAT_FULL)
						n_full++;
					if (want.status == csl_pkg::STAT_NOITEM)
						n_noitem++;
					n_checked++;
				end
			end
			rsp_ready <= !hold_rsp && ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Abort when neither channel moves for too long
	always @(posedge clk) begin : watchdog
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty-list rejects, edges of the data word, every mode
		push_cmd(csl_pkg::MODE_READ, 32'h0000_0000);
		push_cmd(csl_pkg::MODE_ADVANCE, 32'hFFFF_FFFF);
		push_cmd(csl_pkg::MODE_REMOVE, 32'h0000_0000);
		push_cmd(csl_pkg::MODE_START, 32'h0000_0000);
		push_cmd(csl_pkg::MODE_ATTACH, 32'hFFFF_FFFF);
		push_cmd(csl_pkg::MODE_INSERT, 32'h0000_0000);
		push_cmd(csl_pkg::MODE_ATTACH, 32'hA5A5_A5A5);
		push_cmd(csl_pkg::MODE_INSERT, 32'h5A5A_5A5A);
		push_cmd(csl_pkg::MODE_READ, 32'h1234_5678);
		push_cmd(MODE_SPARE_A, 32'hFFFF_FFFF);
		push_cmd(MODE_SPARE_B, 32'h0000_0000);
		push_cmd(csl_pkg::MODE_START, 32'h0000_0000);
		push_cmd(csl_pkg::MODE_ADVANCE, 32'h0000_0000);
		push_cmd(csl_pkg::MODE_REMOVE, 32'h0000_0000);
		push_cmd(csl_pkg::MODE_ADVANCE, 32'h0000_0000);
		push_cmd(csl_pkg::MODE_ADVANCE, 32'h0000_0000);
		push_cmd(csl_pkg::MODE_ADVANCE, 32'h0000_0000);
		push_cmd(csl_pkg::MODE_READ, 32'h0000_0000);
		push_cmd(csl_pkg::MODE_REMOVE, 32'h0000_0000);
		push_cmd(csl_pkg::MODE_INSERT, 32'h8000_0001);
		push_cmd(csl_pkg::MODE_ADVANCE, 32'h0000_0000);
		push_cmd(csl_pkg::MODE_ADVANCE, 32'h0000_0000);
		push_cmd(csl_pkg::MODE_ADVANCE, 32'h0000_0000);
		push_cmd(csl_pkg::MODE_ATTACH, 32'h7FFF_FFFE);
		wait_drained();

		// Random bursts with no idling on either side
		queue_random(440);
		wait_drained();

		// Sender mostly idle
		send_idle_pct <= 81;
		queue_random(360);
		wait_drained();

		// Receiver mostly stalled
		send_idle_pct  <= 0;
		recv_stall_pct <= 81;
		queue_random(360);
		wait_drained();

		// Both sides idling
		send_idle_pct  <= 23;
		recv_stall_pct <= 23;
		queue_random(300);
		wait_drained();

		// Hold off replies while requests keep coming so the input backs up
		send_idle_pct  <= 0;
		recv_stall_pct <= 0;
		hold_rsp       <= 1'b1;
		queue_random(70);
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_rsp <= 1'b0;
		wait_drained();

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Ran %0d requests through empty, partial and full lists, %0d replies checked",
			n_accepted, n_checked);
		$display("Rejects seen: %0d full, %0d no current item; peak item count %0d",
			n_full, n_noitem, peak_count);
		if (n_errors == 0 && expected_replies.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// ----- cursor_sequence_list_unit.f -----
hw/rtl/csl_pkg.sv
hw/rtl/csl_ram.sv
hw/rtl/csl_ctrl.sv
hw/rtl/cursor_sequence_list_unit.sv
hw/rtl/csl_chk.sv
tb/cursor_sequence_list_unit_tb.sv
